### design/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  localparam int CFG_W                = 7;
  localparam int WINDOW_MAX_DEFAULT   = 64;
  localparam int SAMPLE_WIDTH_DEFAULT = 16;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(3);

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic load;   // an item is accepted this cycle
    logic clear;  // item starts a new sequence
    logic pop;    // departing sample equals the queue front
    logic full;   // every entry survives the discard: drop the front
  } swm_ctrl_t;

endpackage

### design/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int INDEX        = 0,
  parameter int KW           = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swm_pkg::swm_ctrl_t      ctrl,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [SAMPLE_WIDTH-1:0] front,
  input  logic [KW-1:0]           tap,
  input  logic [SAMPLE_WIDTH-1:0] hist_in,
  output logic [SAMPLE_WIDTH-1:0] hist,
  output logic                    hit,
  input  logic [SAMPLE_WIDTH-1:0] cand_in,
  input  logic                    cand_valid_in,
  input  logic                    keep_in,
  output logic [SAMPLE_WIDTH-1:0] cand,
  output logic                    cand_valid,
  output logic                    keep,
  output logic [SAMPLE_WIDTH-1:0] cand_next
);
  import swm_pkg::*;

  logic [SAMPLE_WIDTH-1:0] cur;
  logic                    cur_valid;
  logic                    cand_valid_next;

  // Entry as seen after a possible front pop.
  assign cur       = ctrl.pop ? cand_in : cand;
  assign cur_valid = ctrl.pop ? cand_valid_in : (cand_valid & ~ctrl.clear);
  assign keep      = cur_valid && !($signed(cur) < $signed(sample));

  // Delay line tap: flag a match between the departing sample and the front.
  assign hit = (tap == KW'(INDEX)) && (hist == front);

  always_comb begin
    cand_next       = cur;
    cand_valid_next = 1'b0;
    if (ctrl.full) begin
      // every slot stays occupied when the row overflows
      cand_next       = cand_in;
      cand_valid_next = 1'b1;
    end else if (keep) begin
      cand_next       = cur;
      cand_valid_next = 1'b1;
    end else if (keep_in) begin
      // first discarded slot takes the new sample
      cand_next       = sample;
      cand_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (ctrl.load) begin
      cand_valid <= cand_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cand <= cand_next;
      hist <= hist_in;
    end
  end

endmodule

### design/sliding_window_maximum.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: sample; tuser: first; tlast: last
// m_*       out  m_tvalid/m_tready  tdata: window_max; tlast: end_of_sequence
// cfg_*     in   cfg_we             cfg_wdata: window_size
//
// One item per cycle while not stalled; each item is settled in the cycle
// it is accepted by a row of WINDOW_MAX cells (delay line stage plus one
// queue slot each). The result lands in an output register; s_tready is
// high whenever that register is empty or being drained.
// Reset clears the queue valid bits, the sample count and the output; the
// window size returns to 3. A stalled output holds the input off.

module sliding_window_maximum #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT,
  localparam int DW          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [DW-1:0]           s_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  logic                    s_tuser,   // [0] first
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [DW-1:0]           m_tdata,   // [SAMPLE_WIDTH-1:0] window_max
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);
  import swm_pkg::*;

  localparam int KW = ($clog2(WINDOW_MAX + 1) > CFG_W) ? $clog2(WINDOW_MAX + 1) : CFG_W;

  logic [CFG_W-1:0]        window_size;
  logic [KW-1:0]           k;
  logic [KW-1:0]           tap;
  logic [KW-1:0]           seen;
  logic [KW-1:0]           seen_cur;
  logic [KW-1:0]           seen_next;
  logic                    produce;
  logic                    load;
  logic                    first;
  logic [SAMPLE_WIDTH-1:0] sample;
  swm_ctrl_t               ctrl;

  logic [SAMPLE_WIDTH-1:0] hist      [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cand      [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cand_next [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]   cand_valid;
  logic [WINDOW_MAX-1:0]   keep;
  logic [WINDOW_MAX-1:0]   hit;

  logic [SAMPLE_WIDTH-1:0] max_q;

  assign sample = s_tdata[SAMPLE_WIDTH-1:0];
  assign first  = s_tuser;
  assign load   = s_tvalid & s_tready;

  // Clamp the window: zero acts as one, oversize acts as the row length.
  always_comb begin
    if (window_size == '0) begin
      k = KW'(1);
    end else if (KW'(window_size) > KW'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_size);
    end
  end
  assign tap = k - KW'(1);

  assign seen_cur  = first ? '0 : seen;
  assign seen_next = (seen_cur < k) ? seen_cur + KW'(1) : k;
  assign produce   = (seen_next == k);

  assign ctrl.load  = load;
  assign ctrl.clear = first;
  assign ctrl.pop   = !first && (seen_cur >= k) && cand_valid[0] && (|hit);
  assign ctrl.full  = keep[WINDOW_MAX-1];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] hist_in;
    logic [SAMPLE_WIDTH-1:0] cand_in;
    logic                    cand_valid_in;
    logic                    keep_in;

    if (i == 0) begin : g_head
      assign hist_in = sample;
      assign keep_in = 1'b1;
    end else begin : g_body
      assign hist_in = hist[i-1];
      assign keep_in = keep[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      // past the end: the new sample on overflow, an empty slot on a pop
      assign cand_in       = sample;
      assign cand_valid_in = 1'b0;
    end else begin : g_link
      assign cand_in       = cand[i+1];
      assign cand_valid_in = cand_valid[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .INDEX        (i),
      .KW           (KW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .sample        (sample),
      .front         (cand[0]),
      .tap           (tap),
      .hist_in       (hist_in),
      .hist          (hist[i]),
      .hit           (hit[i]),
      .cand_in       (cand_in),
      .cand_valid_in (cand_valid_in),
      .keep_in       (keep_in),
      .cand          (cand[i]),
      .cand_valid    (cand_valid[i]),
      .keep          (keep[i]),
      .cand_next     (cand_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (load) begin
      seen <= seen_next;
    end
  end

  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= produce;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && produce) begin
      max_q   <= cand_next[0];
      m_tlast <= s_tlast;
    end
  end

  assign m_tdata = DW'(max_q);

  // Queue slots fill from the front with no holes.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cand_valid >> 1) & ~cand_valid) == '0)
    else $error("queue valid bits not a prefix");

  a_front: assert property (@(posedge clk) disable iff (rst)
    load |=> cand_valid[0])
    else $error("queue empty after an item");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (load && produce) |=> (m_tvalid && (m_tdata[SAMPLE_WIDTH-1:0] == cand[0])))
    else $error("result does not match queue front");

endmodule
